// ----- design/apt_pkg.sv -----
// apt_pkg: shared constants and types for the aabb proxy table
// no dependencies

package apt_pkg;

    localparam int CAPACITY    = 32;
    localparam int COORD_WIDTH = 16;
    localparam int ID_W        = 5;
    localparam int TAG_W       = 32;
    localparam int MARGIN_W    = 12;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_QUERY  = 3'd3;
    localparam logic [2:0] OP_RDTAG  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_NOSLOT = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t lx;
        coord_t ly;
        coord_t hx;
        coord_t hy;
    } box_t;

    // controller to datapath
    typedef struct packed {
        logic            rd;        // read box/tag memories at rd_addr
        logic [ID_W-1:0] rd_addr;
        logic            wr_box;    // write fat box at wr_addr
        logic            wr_tag;
        logic [ID_W-1:0] wr_addr;
    } apt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic contained; // request box inside stored box
        logic overlap;   // request box overlaps stored box
    } apt_sts_t;

    function automatic coord_t sat_add(coord_t a, logic [MARGIN_W-1:0] m, logic sub);
        logic signed [COORD_WIDTH+1:0] s;
        logic signed [COORD_WIDTH+1:0] hi;
        logic signed [COORD_WIDTH+1:0] lo;
        hi = (COORD_WIDTH+2)'((1 <<< (COORD_WIDTH-1)) - 1);
        lo = -hi - (COORD_WIDTH+2)'(1);
        if (sub)
            s = (COORD_WIDTH+2)'(a) - $signed({1'b0, (COORD_WIDTH+1)'(m)});
        else
            s = (COORD_WIDTH+2)'(a) + $signed({1'b0, (COORD_WIDTH+1)'(m)});
        if (s > hi)
            return hi[COORD_WIDTH-1:0];
        else if (s < lo)
            return lo[COORD_WIDTH-1:0];
        else
            return s[COORD_WIDTH-1:0];
    endfunction

endpackage

// ----- design/apt_datapath.sv -----
// apt_datapath: box and tag memories, fat-box widening and compares
// depends on apt_pkg

module apt_datapath
    import apt_pkg::*;
(
    input  logic                 clk,
    input  apt_cmd_t             cmd,
    input  box_t                 req_box,
    input  logic [TAG_W-1:0]     req_tag,
    input  logic [MARGIN_W-1:0]  fat_margin,
    output apt_sts_t             sts,
    output logic [TAG_W-1:0]     tag_rd
);

    box_t             box_mem [CAPACITY];
    logic [TAG_W-1:0] tag_mem [CAPACITY];
    box_t             box_rd_reg;
    box_t             fat;

    always_comb
    begin
        fat.lx = sat_add(req_box.lx, fat_margin, 1'b1);
        fat.ly = sat_add(req_box.ly, fat_margin, 1'b1);
        fat.hx = sat_add(req_box.hx, fat_margin, 1'b0);
        fat.hy = sat_add(req_box.hy, fat_margin, 1'b0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_box)
            box_mem[cmd.wr_addr] <= fat;
        if (cmd.wr_tag)
            tag_mem[cmd.wr_addr] <= req_tag;
        if (cmd.rd)
        begin
            box_rd_reg <= box_mem[cmd.rd_addr];
            tag_rd     <= tag_mem[cmd.rd_addr];
        end
    end

    always_comb
    begin
        sts.contained = (box_rd_reg.lx <= req_box.lx) && (box_rd_reg.ly <= req_box.ly) &&
                        (req_box.hx <= box_rd_reg.hx) && (req_box.hy <= box_rd_reg.hy);
        sts.overlap   = (box_rd_reg.lx <= req_box.hx) && (req_box.lx <= box_rd_reg.hx) &&
                        (box_rd_reg.ly <= req_box.hy) && (req_box.ly <= box_rd_reg.hy);
    end

endmodule

// ----- design/apt_ctrl.sv -----
// apt_ctrl: sequencer, valid bits and lifo free list
// depends on apt_pkg

module apt_ctrl
    import apt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [2:0]        op,
    input  logic [ID_W-1:0]   entry_id,
    input  apt_sts_t          sts,
    input  logic [TAG_W-1:0]  tag_rd,
    input  logic              out_free,   // output register empty or being taken
    output apt_cmd_t          cmd,
    output logic              busy,
    output logic              res_load,
    output logic [ID_W-1:0]   res_id,
    output logic              res_hit,
    output logic              res_refit,
    output logic [TAG_W-1:0]  res_tag,
    output logic [1:0]        res_status,
    output logic              res_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UPD   = 3'd1;
    localparam logic [2:0] S_RDT   = 3'd2;
    localparam logic [2:0] S_QRY   = 3'd3;
    localparam logic [2:0] S_QEND  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [ID_W:0]       free_next_reg [CAPACITY];
    logic [ID_W:0]       free_head_reg, free_head_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [ID_W:0]       scan_reg, scan_next;    // slot whose data is in the read register
    logic                chk_reg, chk_next;      // read register holds a scanned slot
    logic                pend_reg, pend_next;    // a hit waits for the output register
    logic [ID_W-1:0]     pend_id_reg, pend_id_next;
    logic                any_reg, any_next;
    logic                fl_wr;
    logic [ID_W-1:0]     fl_addr;
    logic [ID_W:0]       fl_data;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        free_head_next = free_head_reg;
        id_next        = id_reg;
        scan_next      = scan_reg;
        chk_next       = 1'b0;
        pend_next      = pend_reg;
        pend_id_next   = pend_id_reg;
        any_next       = any_reg;
        fl_wr          = 1'b0;
        fl_addr        = entry_id;
        fl_data        = free_head_reg;
        cmd            = '0;
        res_load       = 1'b0;
        res_id         = '0;
        res_hit        = 1'b0;
        res_refit      = 1'b0;
        res_tag        = '0;
        res_status     = ST_OK;
        res_last       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    id_next = entry_id;
                    case (op)
                        OP_INSERT:
                        begin
                            res_load = 1'b1;
                            if (free_head_reg[ID_W])
                                res_status = ST_FULL;
                            else
                            begin
                                cmd.wr_box = 1'b1;
                                cmd.wr_tag = 1'b1;
                                cmd.wr_addr = free_head_reg[ID_W-1:0];
                                valid_next[free_head_reg[ID_W-1:0]] = 1'b1;
                                free_head_next = free_next_reg[free_head_reg[ID_W-1:0]];
                                res_id = free_head_reg[ID_W-1:0];
                            end
                            state_next = S_DONE;
                        end
                        OP_REMOVE:
                        begin
                            res_load = 1'b1;
                            res_id = entry_id;
                            if (!valid_reg[entry_id])
                                res_status = ST_NOSLOT;
                            else
                            begin
                                fl_wr = 1'b1;
                                free_head_next = {1'b0, entry_id};
                                valid_next[entry_id] = 1'b0;
                            end
                            state_next = S_DONE;
                        end
                        OP_UPDATE, OP_RDTAG:
                        begin
                            if (!valid_reg[entry_id])
                            begin
                                res_load = 1'b1;
                                res_id = entry_id;
                                res_status = ST_NOSLOT;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cmd.rd = 1'b1;
                                cmd.rd_addr = entry_id;
                                state_next = (op == OP_UPDATE) ? S_UPD : S_RDT;
                            end
                        end
                        OP_QUERY:
                        begin
                            cmd.rd = 1'b1;
                            cmd.rd_addr = '0;
                            scan_next = '0;
                            chk_next = 1'b1;
                            pend_next = 1'b0;
                            any_next = 1'b0;
                            state_next = S_QRY;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    res_id = id_reg;
                    if (!sts.contained)
                    begin
                        res_refit = 1'b1;
                        cmd.wr_box = 1'b1;
                        cmd.wr_addr = id_reg;
                    end
                    state_next = S_DONE;
                end
            end
            S_RDT:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    res_id = id_reg;
                    res_tag = tag_rd;
                    state_next = S_DONE;
                end
            end
            S_QRY:
            begin
                // one slot per cycle unless stalled; a held hit is sent at the next hit
                if (!pend_reg || out_free)
                begin
                    if (pend_reg && chk_reg && valid_reg[scan_reg[ID_W-1:0]] && sts.overlap)
                    begin
                        res_load = 1'b1;
                        res_id = pend_id_reg;
                        res_hit = 1'b1;
                        res_last = 1'b0;
                    end
                    if (chk_reg && valid_reg[scan_reg[ID_W-1:0]] && sts.overlap)
                    begin
                        pend_next = 1'b1;
                        pend_id_next = scan_reg[ID_W-1:0];
                        any_next = 1'b1;
                    end
                    if (scan_reg == (ID_W+1)'(CAPACITY - 1))
                        state_next = S_QEND;
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                        cmd.rd = 1'b1;
                        cmd.rd_addr = scan_next[ID_W-1:0];
                        chk_next = 1'b1;
                    end
                end
                else
                    chk_next = chk_reg;
            end
            S_QEND:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    res_id = any_reg ? pend_id_reg : '0;
                    res_hit = any_reg;
                    pend_next = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            free_head_reg <= '0;
            pend_reg      <= 1'b0;
            chk_reg       <= 1'b0;
            any_reg       <= 1'b0;
            for (int i = 0; i < CAPACITY; i++)
                free_next_reg[i] <= (i + 1 < CAPACITY) ? (ID_W+1)'(i + 1) : {(ID_W+1){1'b1}};
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            free_head_reg <= free_head_next;
            pend_reg      <= pend_next;
            chk_reg       <= chk_next;
            any_reg       <= any_next;
            if (fl_wr)
                free_next_reg[fl_addr] <= fl_data;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        scan_reg    <= scan_next;
        pend_id_reg <= pend_id_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> state_reg == S_IDLE)
        else $error("done state not followed by idle");
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && state_reg != S_IDLE) |-> out_free)
        else $error("result loaded into a full output register");
    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_tag |=> valid_reg[$past(cmd.wr_addr)])
        else $error("inserted slot not marked valid");

endmodule

// ----- design/aabb_proxy_table_unit.sv -----
// aabb_proxy_table_unit: top level of the broad-phase box table
// depends on apt_pkg, apt_ctrl, apt_datapath
//
// channel  | dir | transfer payload
// s_axis   | in  | op, entry_id, box, tag
// m_axis   | out | result_id, hit, refit, tag_out, status; tlast = last
// cfg      | in  | fat_margin write
//
// insert and remove load their result on acceptance; update and read tag first read memory
// a query compares one slot per cycle over 32 slots while no held hit waits for m_axis,
// after the first memory read and before the final result, paced by the single read port
// reset clears valid bits and rebuilds the free list at once; memories are not cleared
// a stalled m_axis holds the scan; s_axis is taken only while the unit is idle
// and the output register is empty or being taken

module aabb_proxy_table_unit
    import apt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [11:0]   cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // op[2:0], entry_id[7:3], min_x[23:8], min_y[39:24], max_x[55:40],
    // max_y[71:56], tag[103:72]
    input  logic [103:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // result_id[4:0], hit[5], refit[6], tag_out[38:7], status[40:39], zero fill
    output logic [47:0]   m_axis_tdata,
    output logic          m_axis_tlast
);

    logic [MARGIN_W-1:0] margin_reg;
    box_t                req_reg;
    logic [TAG_W-1:0]    tag_reg;
    apt_cmd_t            cmd;
    apt_sts_t            sts;
    logic [TAG_W-1:0]    tag_rd;
    logic                busy, in_fire, out_free, res_load;
    logic [ID_W-1:0]     res_id;
    logic                res_hit, res_refit, res_last;
    logic [TAG_W-1:0]    res_tag;
    logic [1:0]          res_status;
    box_t                cur_box;
    logic [TAG_W-1:0]    cur_tag;

    // insert and remove load their result in the accepting cycle
    assign s_axis_tready = !busy && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_axis_tvalid || m_axis_tready;

    // the insert writes from the live transfer, later ops from the held request
    assign cur_box = in_fire ? box_t'({s_axis_tdata[23:8], s_axis_tdata[39:24],
                                       s_axis_tdata[55:40], s_axis_tdata[71:56]})
                             : req_reg;
    assign cur_tag = in_fire ? s_axis_tdata[103:72] : tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            margin_reg <= 12'd32;
        else if (cfg_we)
            margin_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= cur_box;
            tag_reg <= cur_tag;
        end
    end

    apt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .op         (s_axis_tdata[2:0]),
        .entry_id   (s_axis_tdata[7:3]),
        .sts        (sts),
        .tag_rd     (tag_rd),
        .out_free   (out_free),
        .cmd        (cmd),
        .busy       (busy),
        .res_load   (res_load),
        .res_id     (res_id),
        .res_hit    (res_hit),
        .res_refit  (res_refit),
        .res_tag    (res_tag),
        .res_status (res_status),
        .res_last   (res_last)
    );

    apt_datapath u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .req_box    (cur_box),
        .req_tag    (cur_tag),
        .fat_margin (margin_reg),
        .sts        (sts),
        .tag_rd     (tag_rd)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (res_load)
            m_axis_tvalid <= 1'b1;
        else if (m_axis_tready)
            m_axis_tvalid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_axis_tdata <= {7'd0, res_status, res_tag, res_refit, res_hit, res_id};
            m_axis_tlast <= res_last;
        end
    end

endmodule
